### sv/crt_pkg.sv
// Shared types, constants and the per-byte parse function of the CSV record tokenizer.
package crt_pkg;

    // Parser states.
    localparam logic [1:0] ST_FIELD_START = 2'd0;
    localparam logic [1:0] ST_IN_FIELD    = 2'd1;
    localparam logic [1:0] ST_IN_QUOTED   = 2'd2;
    localparam logic [1:0] ST_QUOTE_SEEN  = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE       = 2'd0;
    localparam logic [1:0] KIND_FIELD_END  = 2'd1;
    localparam logic [1:0] KIND_RECORD_END = 2'd2;
    localparam logic [1:0] KIND_ERROR      = 2'd3;

    // Special characters.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Most results one input word can cause.
    localparam int MAX_RESULTS = 3;

    // Default depth of the queue between the parser and the output side.
    localparam int QUEUE_DEPTH = 4;

    // One result word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [31:0] index;
    } t_result;

    // All results of one input word, in order, with their count.
    typedef struct packed {
        logic [1:0]                   count;
        t_result [MAX_RESULTS-1:0]    res;
    } t_bundle;

    // Outcome of feeding one character to the parser.
    typedef struct packed {
        logic [1:0] st;
        logic       fne;
        logic       rhf;
        logic       emit;
        logic       close;
        logic [1:0] kind;
        logic [7:0] data;
    } t_proc;

    // Printable character other than the quote and the delimiter.
    function automatic logic crt_is_text(input logic [7:0] c, input logic [7:0] delim);
        return (c inside {[8'h20:8'h21], [8'h23:8'h7E]}) && (c != delim);
    endfunction

    // One step of the four-state field parser.
    function automatic t_proc crt_process(
        input logic [1:0] st,
        input logic       fne,
        input logic       rhf,
        input logic [7:0] c,
        input logic [7:0] delim
    );
        t_proc p;
        logic  do_push;
        logic  do_end_field;
        logic  do_close;
        logic  is_err;
        logic  push_quote;
        do_push      = 1'b0;
        do_end_field = 1'b0;
        do_close     = 1'b0;
        is_err       = 1'b0;
        push_quote   = 1'b0;
        p.st         = st;
        case (st)
            ST_FIELD_START: begin
                if (c == CH_QUOTE) begin
                    p.st = ST_IN_QUOTED;
                end else if (c == delim) begin
                    do_end_field = 1'b1;
                end else if (c == CH_LF) begin
                    do_close = 1'b1;
                end else begin
                    do_push = 1'b1;
                    p.st    = ST_IN_FIELD;
                end
            end
            ST_IN_FIELD: begin
                if (c == CH_LF) begin
                    do_close = 1'b1;
                end else if (c == delim) begin
                    do_end_field = 1'b1;
                end else if (crt_is_text(c, delim)) begin
                    do_push = 1'b1;
                end else begin
                    do_close = 1'b1;
                    is_err   = 1'b1;
                end
            end
            ST_IN_QUOTED: begin
                if (c == CH_QUOTE) begin
                    p.st = ST_QUOTE_SEEN;
                end else if (crt_is_text(c, delim) || c == delim || c == CH_CR
                             || c == CH_LF) begin
                    do_push = 1'b1;
                end else begin
                    do_close = 1'b1;
                    is_err   = 1'b1;
                end
            end
            default: begin
                if (c == CH_QUOTE) begin
                    do_push    = 1'b1;
                    push_quote = 1'b1;
                    p.st       = ST_IN_QUOTED;
                end else if (c == delim) begin
                    do_end_field = 1'b1;
                end else if (c == CH_LF) begin
                    do_close = 1'b1;
                end else begin
                    do_close = 1'b1;
                    is_err   = 1'b1;
                end
            end
        endcase

        p.fne   = fne;
        p.rhf   = rhf;
        p.emit  = do_push || do_end_field || do_close;
        p.close = do_close;
        p.kind  = KIND_BYTE;
        p.data  = 8'h00;
        if (do_push) begin
            p.fne  = 1'b1;
            p.data = push_quote ? CH_QUOTE : c;
        end
        if (do_end_field) begin
            p.kind = KIND_FIELD_END;
            p.rhf  = 1'b1;
            p.fne  = 1'b0;
            p.st   = ST_FIELD_START;
        end
        if (do_close) begin
            p.kind = is_err ? KIND_ERROR : KIND_RECORD_END;
            p.fne  = 1'b0;
            p.rhf  = 1'b0;
            p.st   = ST_FIELD_START;
        end
        return p;
    endfunction

endpackage

### sv/crt_front.sv
// Front end: delimiter register, CR folding, parser state and result bundling per input word.
module crt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [7:0]      i_cfg_wr_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_input,
    input  logic            i_q_full,
    output logic            o_push,
    output crt_pkg::t_bundle o_bundle
);
    import crt_pkg::*;

    logic [7:0]  r_delim;
    logic [1:0]  r_st;
    logic        r_fne;
    logic        r_rhf;
    logic        r_pending_cr;
    logic [31:0] r_cnt;

    logic [1:0]  n_st;
    logic        n_fne;
    logic        n_rhf;
    logic        n_pending_cr;
    logic [31:0] n_cnt;

    t_proc       p1;
    t_proc       p2;
    logic        use1;
    logic        do2;
    logic        e1;
    logic        e2;
    logic        e3;
    logic [1:0]  s1_st;
    logic        s1_fne;
    logic        s1_rhf;
    logic [1:0]  s2_st;
    logic        s2_fne;
    logic        s2_rhf;
    logic [7:0]  c2;
    logic [1:0]  close12;
    logic [1:0]  close_all;
    logic        accept;
    t_result     res1;
    t_result     res2;
    t_result     res3;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !i_q_full;

    // A held CR is replayed as a plain CR unless this word is its LF.
    assign use1 = r_pending_cr && (i_in_byte != CH_LF);
    assign p1   = crt_process(r_st, r_fne, r_rhf, CH_CR, r_delim);
    assign e1   = use1 && p1.emit;

    always_comb begin
        if (use1) begin
            s1_st  = p1.st;
            s1_fne = p1.fne;
            s1_rhf = p1.rhf;
        end else begin
            s1_st  = r_st;
            s1_fne = r_fne;
            s1_rhf = r_rhf;
        end
    end

    // A CR is held for the next word, except on the final word where it acts as LF.
    assign do2 = !((i_in_byte == CH_CR) && !i_end_of_input);
    assign c2  = (i_in_byte == CH_CR) ? CH_LF : i_in_byte;
    assign p2  = crt_process(s1_st, s1_fne, s1_rhf, c2, r_delim);
    assign e2  = do2 && p2.emit;

    always_comb begin
        if (do2) begin
            s2_st  = p2.st;
            s2_fne = p2.fne;
            s2_rhf = p2.rhf;
        end else begin
            s2_st  = s1_st;
            s2_fne = s1_fne;
            s2_rhf = s1_rhf;
        end
    end

    // End of input closes a record that has any content.
    assign e3 = i_end_of_input && (s2_fne || s2_rhf);

    // Record numbers: each close advances the counter after its own result.
    assign close12   = {1'b0, e1 && p1.close} + {1'b0, e2 && p2.close};
    assign close_all = close12 + {1'b0, e3};

    always_comb begin
        res1.kind  = p1.kind;
        res1.data  = p1.data;
        res1.index = r_cnt;
        res2.kind  = p2.kind;
        res2.data  = p2.data;
        res2.index = r_cnt + {31'd0, e1 && p1.close};
        res3.kind  = KIND_RECORD_END;
        res3.data  = 8'h00;
        res3.index = r_cnt + {30'd0, close12};
    end

    // Pack the emitted results into the lowest slots, in order.
    always_comb begin
        o_bundle.count  = {1'b0, e1} + {1'b0, e2} + {1'b0, e3};
        o_bundle.res[2] = res3;
        if (e1) begin
            o_bundle.res[0] = res1;
        end else if (e2) begin
            o_bundle.res[0] = res2;
        end else begin
            o_bundle.res[0] = res3;
        end
        if (e1 && e2) begin
            o_bundle.res[1] = res2;
        end else begin
            o_bundle.res[1] = res3;
        end
    end

    assign o_push = accept && (o_bundle.count != 2'd0);

    // Next parser state.
    always_comb begin
        n_cnt = r_cnt + {30'd0, close_all};
        if (i_end_of_input) begin
            n_st         = ST_FIELD_START;
            n_fne        = 1'b0;
            n_rhf        = 1'b0;
            n_pending_cr = 1'b0;
        end else begin
            n_st         = s2_st;
            n_fne        = s2_fne;
            n_rhf        = s2_rhf;
            n_pending_cr = (i_in_byte == CH_CR);
        end
    end

    // Delimiter register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= CH_COMMA;
        end else if (i_cfg_wr_en) begin
            r_delim <= i_cfg_wr_data;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= ST_FIELD_START;
            r_fne        <= 1'b0;
            r_rhf        <= 1'b0;
            r_pending_cr <= 1'b0;
            r_cnt        <= 32'd0;
        end else if (accept) begin
            r_st         <= n_st;
            r_fne        <= n_fne;
            r_rhf        <= n_rhf;
            r_pending_cr <= n_pending_cr;
            r_cnt        <= n_cnt;
        end
    end

endmodule

### sv/crt_queue.sv
// Short queue of result bundles between the parser and the output side.
module crt_queue #(
    parameter int DEPTH = crt_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  crt_pkg::t_bundle i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output crt_pkg::t_bundle o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import crt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle             r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage, written at the tail.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/crt_back.sv
// Back end: holds one bundle; emits one result word per cycle while ready.
module crt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  crt_pkg::t_bundle i_q_data,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [31:0]      o_record_index,
    output logic             o_last,
    output logic [1:0]       o_sel,
    output logic [1:0]       o_held_count
);
    import crt_pkg::*;

    logic       r_valid;
    t_bundle    r_bundle;
    logic [1:0] r_sel;
    logic       take;
    logic       last;
    logic       load;
    t_result    cur;

    assign take = r_valid && i_out_ready;
    assign last = (r_sel == (r_bundle.count - 2'd1));
    assign load = !r_valid || (take && last);
    assign o_pop = load && i_q_valid;

    // Pick the current result of the held bundle.
    always_comb begin
        case (r_sel)
            2'd0:    cur = r_bundle.res[0];
            2'd1:    cur = r_bundle.res[1];
            default: cur = r_bundle.res[2];
        endcase
    end

    assign o_out_valid    = r_valid;
    assign o_kind         = cur.kind;
    assign o_data_byte    = cur.data;
    assign o_record_index = cur.index;
    assign o_last         = last;
    assign o_sel          = r_sel;
    assign o_held_count   = r_bundle.count;

    // Bundle register and result pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 2'd0;
        end else if (load) begin
            r_valid <= i_q_valid;
            r_sel   <= 2'd0;
        end else if (take) begin
            r_sel <= r_sel + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_bundle <= i_q_data;
        end
    end

endmodule

### sv/csv_record_tokenizer_core.sv
// Top level of the CSV record tokenizer: parser front end, bundle queue and output stage.
// A word's results are registered in the bundle queue and then in the output stage
// before they appear at the output.
// Throughput: one input word per cycle while the queue has room; a word causing two or
// three results holds the output stage until all are taken, which the queue absorbs.
// Reset (synchronous, active low): parser at field start, flags and record counter
// cleared, delimiter back to comma, queue and output stage empty.
module csv_record_tokenizer_core #(
    parameter int QUEUE_DEPTH = crt_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_record_index,
    output logic        o_last
);
    import crt_pkg::*;

    logic                           q_push;
    t_bundle                        q_in;
    logic                           q_full;
    logic                           q_pop;
    logic                           q_valid;
    t_bundle                        q_out;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    logic [1:0]                     b_sel;
    logic [1:0]                     b_count;

    // Parser front end.
    crt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_bundle       (q_in)
    );

    // Bundle queue.
    crt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    // Output stage.
    crt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_out),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_record_index (o_record_index),
        .o_last         (o_last),
        .o_sel          (b_sel),
        .o_held_count   (b_count)
    );

    // The queue never holds more bundles than it has room for.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("bundle queue overfilled");

    // Only bundles with at least one result are queued.
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_in.count != 2'd0))
        else $error("empty bundle pushed");

    // The output pointer stays inside the held bundle.
    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (b_sel < b_count))
        else $error("output pointer beyond bundle");

    // Within a bundle, a record end or error is followed by the next record number.
    a_index_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last
         && (o_kind == KIND_RECORD_END || o_kind == KIND_ERROR))
        |=> (o_record_index == $past(o_record_index) + 32'd1))
        else $error("record number did not advance");

endmodule

### tb/tb_csv_record_tokenizer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CSV record tokenizer core, with a built-in parser predictor.
module tb_csv_record_tokenizer_core;
    import crt_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_BYTES  = 500;
    localparam int PRINT_CAP     = 100;

    // One expected output word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [31:0] index;
        logic        last;
    } t_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [31:0] o_record_index;
    logic        o_last;

    // Predictor state.
    logic [7:0]  delim_model;
    logic [1:0]  parse_st;
    logic        cr_held;
    logic        fld_has_data;
    logic        rec_has_fld;
    logic [31:0] rec_count;
    t_token      word_tokens[$];
    t_token      expected_tokens[$];

    // Delimiter the stimulus builds records with.
    logic [7:0]  stim_delim = CH_COMMA;

    int          mismatches = 0;
    int          sent_bytes = 0;
    int          cycle_count = 0;
    logic        no_idle = 1'b0;

    csv_record_tokenizer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_record_index (o_record_index),
        .o_last         (o_last)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run-length guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // The output side stalls at random unless idling is switched off.
    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= 27);
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("error at cycle %0d: %s", cycle_count, msg);
        end
        mismatches++;
    endtask

    // Printable byte other than the quote and the current delimiter.
    function automatic logic is_plain_char(input logic [7:0] c);
        return ((c >= 8'h20 && c <= 8'h21) || (c >= 8'h23 && c <= 8'h7E)) && c != delim_model;
    endfunction

    function automatic void add_token(input logic [1:0] k, input logic [7:0] d);
        t_token t;
        if (word_tokens.size() < MAX_RESULTS) begin
            t.kind  = k;
            t.data  = d;
            t.index = rec_count;
            t.last  = 1'b0;
            word_tokens.insert(word_tokens.size(), t);
        end
    endfunction

    function automatic void close_record_model(input logic [1:0] k);
        add_token(k, 8'h00);
        rec_count    = rec_count + 32'd1;
        parse_st     = ST_FIELD_START;
        fld_has_data = 1'b0;
        rec_has_fld  = 1'b0;
    endfunction

    function automatic void end_field_model();
        add_token(KIND_FIELD_END, 8'h00);
        rec_has_fld  = 1'b1;
        fld_has_data = 1'b0;
        parse_st     = ST_FIELD_START;
    endfunction

    function automatic void push_char_model(input logic [7:0] c);
        add_token(KIND_BYTE, c);
        fld_has_data = 1'b1;
    endfunction

    // Feeds one character (after line-break folding) to the four-state parser.
    function automatic void feed_char(input logic [7:0] c);
        case (parse_st)
            ST_FIELD_START: begin
                if (c == CH_QUOTE) begin
                    parse_st = ST_IN_QUOTED;
                end else if (c == delim_model) begin
                    end_field_model();
                end else if (c == CH_LF) begin
                    close_record_model(KIND_RECORD_END);
                end else begin
                    push_char_model(c);
                    parse_st = ST_IN_FIELD;
                end
            end
            ST_IN_FIELD: begin
                if (c == CH_LF) begin
                    close_record_model(KIND_RECORD_END);
                end else if (c == delim_model) begin
                    end_field_model();
                end else if (is_plain_char(c)) begin
                    push_char_model(c);
                end else begin
                    close_record_model(KIND_ERROR);
                end
            end
            ST_IN_QUOTED: begin
                if (c == CH_QUOTE) begin
                    parse_st = ST_QUOTE_SEEN;
                end else if (is_plain_char(c) || c == delim_model || c == CH_CR
                             || c == CH_LF) begin
                    push_char_model(c);
                end else begin
                    close_record_model(KIND_ERROR);
                end
            end
            default: begin
                if (c == CH_QUOTE) begin
                    push_char_model(CH_QUOTE);
                    parse_st = ST_IN_QUOTED;
                end else if (c == delim_model) begin
                    end_field_model();
                end else if (c == CH_LF) begin
                    close_record_model(KIND_RECORD_END);
                end else begin
                    close_record_model(KIND_ERROR);
                end
            end
        endcase
    endfunction

    // Works out every output word caused by one accepted input word.
    function automatic void predict_word(input logic [7:0] c, input logic eoi);
        t_token t;
        int     n;
        word_tokens.delete();
        // A held CR is dropped when LF follows, otherwise it goes in as a plain CR.
        if (cr_held) begin
            cr_held = 1'b0;
            if (c != CH_LF) begin
                feed_char(CH_CR);
            end
        end
        if (c == CH_CR) begin
            if (eoi) begin
                feed_char(CH_LF);
            end else begin
                cr_held = 1'b1;
            end
        end else begin
            feed_char(c);
        end
        // End of input flushes any open record and clears the parser.
        if (eoi) begin
            if (fld_has_data || rec_has_fld) begin
                close_record_model(KIND_RECORD_END);
            end
            parse_st     = ST_FIELD_START;
            fld_has_data = 1'b0;
            rec_has_fld  = 1'b0;
            cr_held      = 1'b0;
        end
        n = word_tokens.size();
        for (int i = 0; i < n; i++) begin
            t      = word_tokens[i];
            t.last = (i == n - 1);
            expected_tokens.insert(expected_tokens.size(), t);
        end
    endfunction

    task automatic check_token();
        t_token exp_t;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind=%0d data=%02h index=%0d",
                                      o_kind, o_data_byte, o_record_index));
        end else begin
            exp_t = expected_tokens.pop_front();
            if (o_kind !== exp_t.kind) begin
                report_mismatch($sformatf("kind %0d, expected %0d", o_kind, exp_t.kind));
            end
            if (o_data_byte !== exp_t.data) begin
                report_mismatch($sformatf("data_byte %02h, expected %02h",
                                          o_data_byte, exp_t.data));
            end
            if (o_record_index !== exp_t.index) begin
                report_mismatch($sformatf("record_index %0d, expected %0d",
                                          o_record_index, exp_t.index));
            end
            if (o_last !== exp_t.last) begin
                report_mismatch($sformatf("last %0b, expected %0b", o_last, exp_t.last));
            end
        end
    endtask

    // Predicts on every accepted input word and checks every accepted output word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            delim_model  = CH_COMMA;
            parse_st     = ST_FIELD_START;
            cr_held      = 1'b0;
            fld_has_data = 1'b0;
            rec_has_fld  = 1'b0;
            rec_count    = 32'd0;
            expected_tokens.delete();
        end else begin
            if (i_cfg_wr_en) begin
                delim_model = i_cfg_wr_data;
            end
            if (i_in_valid && o_in_ready) begin
                predict_word(i_in_byte, i_end_of_input);
            end
            if (o_out_valid && i_out_ready) begin
                check_token();
            end
        end
    end

    // Sends one input word, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        while (!no_idle && $urandom_range(0, 99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_byte      <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (!o_in_ready);
        sent_bytes++;
    endtask

    task automatic send_text(input string s, input logic eoi_on_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], eoi_on_last && (i == s.len() - 1));
        end
    endtask

    // Holds the sender until every expected word has come, then lets the pipe settle.
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_delimiter(input logic [7:0] d);
        drain_and_settle();
        stim_delim    = d;
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= d;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == CH_QUOTE || c == stim_delim);
        return c;
    endfunction

    // Builds one mostly well-formed record with random content and sends it.
    task automatic send_random_record();
        logic [7:0] rec[$];
        int         nf;
        int         len;
        int         mode;
        int         cut;
        logic       eoi_at_end;
        nf         = $urandom_range(1, 4);
        eoi_at_end = 1'b0;
        for (int f = 0; f < nf; f++) begin
            mode = $urandom_range(0, 99);
            len  = $urandom_range(0, 5);
            if (mode < 10) begin
                // Noise: stray CR or any byte at all.
                rec.insert(rec.size(),
                           ($urandom_range(0, 99) < 30) ? CH_CR : 8'($urandom_range(0, 255)));
            end else if (mode < 60) begin
                for (int i = 0; i < len; i++) begin
                    rec.insert(rec.size(), pick_text_char());
                end
            end else begin
                rec.insert(rec.size(), CH_QUOTE);
                for (int i = 0; i < len; i++) begin
                    mode = $urandom_range(0, 99);
                    if (mode < 70) begin
                        rec.insert(rec.size(), pick_text_char());
                    end else if (mode < 78) begin
                        rec.insert(rec.size(), stim_delim);
                    end else if (mode < 86) begin
                        rec.insert(rec.size(), CH_QUOTE);
                        rec.insert(rec.size(), CH_QUOTE);
                    end else if (mode < 93) begin
                        rec.insert(rec.size(), CH_CR);
                        rec.insert(rec.size(), CH_LF);
                    end else begin
                        rec.insert(rec.size(), CH_LF);
                    end
                end
                rec.insert(rec.size(), CH_QUOTE);
            end
            if (f != nf - 1) begin
                rec.insert(rec.size(), stim_delim);
            end
        end
        // Record end: LF, CR LF, or end of input.
        mode = $urandom_range(0, 99);
        if (mode < 55) begin
            rec.insert(rec.size(), CH_LF);
        end else if (mode < 90) begin
            rec.insert(rec.size(), CH_CR);
            rec.insert(rec.size(), CH_LF);
        end else begin
            eoi_at_end = 1'b1;
        end
        if (rec.size() == 0) begin
            rec.insert(rec.size(), CH_LF);
        end
        // Occasionally break the record or end the text early.
        if ($urandom_range(0, 99) < 10) begin
            rec[$urandom_range(0, rec.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < 6) begin
            eoi_at_end = 1'b1;
        end
        if ($urandom_range(0, 99) < 4) begin
            cut = $urandom_range(1, rec.size());
            while (rec.size() > cut) begin
                void'(rec.pop_back());
            end
            eoi_at_end = 1'b1;
        end
        for (int i = 0; i < rec.size(); i++) begin
            send_byte(rec[i], eoi_at_end && (i == rec.size() - 1));
        end
    endtask

    // Unquoted fields, doubled quotes, delimiter after a closing quote, empty field.
    task automatic test_quoting();
        send_text("a,\"x\"\"y\",\n", 1'b0);
    endtask

    // CR LF inside quotes and as a record end.
    task automatic test_line_breaks();
        send_text("\"p\r\n\"\r\n", 1'b0);
    endtask

    // High byte at field start, control bytes in fields, junk after a closing quote.
    task automatic test_bad_bytes();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("\"a\"b", 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h01, 1'b0);
    endtask

    // End of input: empty quoted field alone, CR as the final byte, lone CR, field flush.
    task automatic test_end_of_input();
        send_text("\"\"", 1'b1);
        send_text("\r", 1'b1);
        send_text("\r~", 1'b1);
    endtask

    // Short records under unusual delimiters, extremes included.
    task automatic test_delimiter_extremes();
        logic [7:0] delims[5];
        delims = '{8'h00, 8'hFF, CH_QUOTE, CH_LF, 8'h09};
        foreach (delims[k]) begin
            write_delimiter(delims[k]);
            send_byte("a", 1'b0);
            send_byte(delims[k], 1'b0);
            send_byte(CH_QUOTE, 1'b0);
            send_byte("b", 1'b0);
            send_byte(delims[k], 1'b0);
            send_byte(CH_QUOTE, 1'b0);
            send_byte(delims[k], 1'b0);
            send_byte("c", 1'b1);
        end
    endtask

    // Random records over several delimiter settings, one phase with no idling,
    // and one pause in the middle until everything has drained.
    task automatic test_random_records();
        logic [7:0] delims[5];
        int         phase_end;
        logic       paused;
        delims = '{CH_COMMA, 8'h09, 8'h3B, 8'h7C, 8'($urandom_range(8'h23, 8'h7E))};
        foreach (delims[p]) begin
            write_delimiter(delims[p]);
            no_idle   = (p == 2);
            paused    = 1'b0;
            phase_end = sent_bytes + RANDOM_BYTES / 5;
            while (sent_bytes < phase_end) begin
                send_random_record();
                if (p == 3 && !paused && sent_bytes > phase_end - RANDOM_BYTES / 10) begin
                    drain_and_settle();
                    paused = 1'b1;
                end
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_quoting();
        test_line_breaks();
        test_bad_bytes();
        test_end_of_input();
        test_delimiter_extremes();
        test_random_records();

        drain_and_settle();
        if (expected_tokens.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never came", expected_tokens.size()));
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
